// ----- src/desrf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desrf_pkg
// Widths, DES E/P/S tables and bit-selection functions for the round function
// ----------------------------------------------------------------------------
package desrf_pkg;

	localparam int HALF_W  = 32;
	localparam int KEY_W   = 48;
	localparam int GROUPS  = 8;
	localparam int GROUP_W = 6;
	localparam int NIB_W   = 4;

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [KEY_W-1:0]  key_t;

	localparam logic [5:0] EXP_TAB [KEY_W] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	localparam logic [5:0] PERM_TAB [HALF_W] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	localparam logic [3:0] SBOX [GROUPS][4][16] = '{
		'{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
		  '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
		  '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
		  '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
		'{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
		  '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
		  '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
		  '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
		'{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
		  '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
		  '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
		  '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
		'{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
		  '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
		  '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
		  '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
		'{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
		  '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
		  '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
		  '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
		'{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
		  '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
		  '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
		  '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
		'{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
		  '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
		  '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
		  '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
		'{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
		  '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
		  '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
		  '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
	};

	// table bit 1 is the msb of the 32-bit word
	function automatic key_t expand(input half_t r);
		key_t       e;
		logic [4:0] idx;
		e = '0;
		for (int k = 0; k < KEY_W; k++) begin
			idx = 5'(6'd32 - EXP_TAB[k]);
			e[KEY_W-1-k] = r[idx];
		end
		return e;
	endfunction

	function automatic half_t permute(input half_t w);
		half_t      p;
		logic [4:0] idx;
		p = '0;
		for (int k = 0; k < HALF_W; k++) begin
			idx = 5'(6'd32 - PERM_TAB[k]);
			p[HALF_W-1-k] = w[idx];
		end
		return p;
	endfunction

endpackage

// ----- src/desrf_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desrf_ifs
// Valid/ready channels for round function inputs and results
// ----------------------------------------------------------------------------
interface desrf_in_if import desrf_pkg::*;;
	logic  valid;
	logic  ready;
	half_t right_half;
	key_t  round_key;

	modport source (output valid, output right_half, output round_key, input ready);
	modport sink (input valid, input right_half, input round_key, output ready);
endinterface

interface desrf_out_if import desrf_pkg::*;;
	logic  valid;
	logic  ready;
	half_t f_value;

	modport source (output valid, output f_value, input ready);
	modport sink (input valid, input f_value, output ready);
endinterface

// ----- src/desrf_sbox_layer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desrf_sbox_layer
// Eight parallel DES S-box lookups, S-box 1 on the most significant group
// ----------------------------------------------------------------------------
module desrf_sbox_layer import desrf_pkg::*; (
	input  key_t  mixed,
	output half_t packed_nib
);

	for (genvar g = 0; g < GROUPS; g++) begin : g_box
		logic [GROUP_W-1:0] six;
		logic [1:0]         row;
		logic [3:0]         col;

		assign six = mixed[KEY_W-1-GROUP_W*g -: GROUP_W];
		assign row = {six[5], six[0]};
		assign col = six[4:1];
		assign packed_nib[HALF_W-1-NIB_W*g -: NIB_W] = SBOX[g][row][col];
	end

endmodule

// ----- src/desrf_round_logic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desrf_round_logic
// Expansion, key mixing, substitution and P permutation of one round
// ----------------------------------------------------------------------------
module desrf_round_logic import desrf_pkg::*; (
	input  half_t right_half,
	input  key_t  round_key,
	output half_t f_value
);

	key_t  mixed;
	half_t packed_nib;

	assign mixed = expand(right_half) ^ round_key;

	desrf_sbox_layer u_sbox (
		.mixed      (mixed),
		.packed_nib (packed_nib)
	);

	assign f_value = permute(packed_nib);

endmodule

// ----- src/des_round_function.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_round_function
// DES Feistel function f for one round, registered in and out
// ----------------------------------------------------------------------------
// Each beat on item carries a 32-bit right half and a 48-bit round subkey and
// gives exactly one beat on result, f(R, K) after the P permutation (no IP).
// The beat is captured in an input register, goes through E expansion, key
// XOR, the eight S-boxes and P combinationally, and lands in a result
// register, and a new beat is taken every cycle while result keeps up.
// Backpressure on result holds the result register, and holds the input
// register as well once it is full.
module des_round_function import desrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	desrf_in_if.sink    item,
	desrf_out_if.source result
);

	logic  valid_s1;
	half_t right_half_s1;
	key_t  round_key_s1;
	logic  valid_s2;
	half_t f_value_s2;
	half_t f_comb;
	logic  adv_s2;
	logic  adv_s1;

	assign adv_s2     = !valid_s2 || result.ready;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item.ready = adv_s1;

	desrf_round_logic u_round (
		.right_half (right_half_s1),
		.round_key  (round_key_s1),
		.f_value    (f_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= item.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item.valid) begin
			right_half_s1 <= item.right_half;
			round_key_s1  <= item.round_key;
		end
		if (adv_s2 && valid_s1) f_value_s2 <= f_comb;
	end

	assign result.valid   = valid_s2;
	assign result.f_value = f_value_s2;

endmodule
